// ===== src/mcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mountain car dynamics package
// Shared widths, fixed-point constants, register indexes and control types.
// ----------------------------------------------------------------------------
package mcd_pkg;

    localparam int FRAC_BITS = 20;
    localparam int MAX_DELAY = 16;

    localparam int POS_W   = 22;
    localparam int VEL_W   = 18;
    localparam int NOISE_W = 21;
    localparam int ACT_W   = 2;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 48;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_ADDR_W-1:0] REG_NOISE_EN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LINEAR   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY    = 2'd2;

    localparam int MW = (FRAC_BITS + 4 > POS_W + 2) ? FRAC_BITS + 4 : POS_W + 2;
    localparam int PW = 2 * MW;
    localparam int AW = (POS_W + 3 > FRAC_BITS + 5) ? POS_W + 3 : FRAC_BITS + 5;

    localparam int PTR_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int EFF_W = ($clog2(MAX_DELAY + 1) > CFG_DATA_W) ?
                           $clog2(MAX_DELAY + 1) : CFG_DATA_W;

    localparam longint ONE_Q     = longint'(1) << FRAC_BITS;
    localparam longint K_ACT     = ((longint'(1) << FRAC_BITS) + 500) / 1000;
    localparam longint K_LIN     = ((longint'(3) << FRAC_BITS) + 200) / 400;
    localparam longint K_COS     = ((longint'(1) << FRAC_BITS) + 200) / 400;
    localparam longint VMAX_Q    = ((longint'(7) << FRAC_BITS) + 50) / 100;
    localparam longint PMIN_Q    = -(((longint'(6) << FRAC_BITS) + 2) / 5);
    localparam longint PMAX_Q    = ((longint'(3) << FRAC_BITS) + 2) / 5;
    localparam longint PI32      = 64'sh3_243F_6A89;
    localparam longint PI_Q      = (PI32 + (longint'(1) << (31 - FRAC_BITS)))
                                   >>> (32 - FRAC_BITS);
    localparam longint HALF_PI_Q = (PI32 + (longint'(1) << (32 - FRAC_BITS)))
                                   >>> (33 - FRAC_BITS);

    // Exact unsigned division of values below 2**DIV_N by reciprocal multiply.
    localparam int     DIV_N = FRAC_BITS + 2;
    localparam int     S56   = DIV_N + 6;
    localparam int     S30   = DIV_N + 5;
    localparam int     S12   = DIV_N + 4;
    localparam longint M56   = ((longint'(1) << S56) + 55) / 56;
    localparam longint M30   = ((longint'(1) << S30) + 29) / 30;
    localparam longint M12   = ((longint'(1) << S12) + 11) / 12;

    typedef enum logic [3:0] {
        OP_SQ,
        OP_D56,
        OP_M1,
        OP_D30,
        OP_M2,
        OP_D12,
        OP_M3,
        OP_KC,
        OP_KL,
        OP_GR
    } mul_op_t;

    typedef struct packed {
        logic    capture;
        logic    reduce;
        logic    mul_en;
        mul_op_t op;
        logic    commit_step;
        logic    commit_load;
    } mcd_cmd_t;

    typedef struct packed {
        logic linear_mode;
    } mcd_status_t;

endpackage
`default_nettype wire

// ===== src/mcd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== src/mcd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mountain car datapath
// Car state, configuration, shared multiplier, delay line and result register.
// ----------------------------------------------------------------------------
module mcd_datapath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [mcd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [mcd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic [mcd_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire mcd_pkg::mcd_cmd_t                cmd,
    output mcd_pkg::mcd_status_t                  status,
    output logic      [mcd_pkg::M_TDATA_W-1:0]    m_tdata
);
    import mcd_pkg::*;

    localparam logic [ACT_W-1:0] ACT_LEFT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd1;
    localparam int NOISE_LO = ACT_W;
    localparam int LPOS_LO  = NOISE_LO + NOISE_W;
    localparam int LVEL_LO  = LPOS_LO + POS_W;
    localparam int OUT_W    = POS_W + VEL_W + 2;

    localparam logic signed [MW-1:0] ONE_M    = MW'(ONE_Q);
    localparam logic signed [MW-1:0] VMAX_M   = MW'(VMAX_Q);
    localparam logic signed [POS_W:0] PMIN_E  = (POS_W + 1)'(PMIN_Q);
    localparam logic signed [POS_W:0] PMAX_E  = (POS_W + 1)'(PMAX_Q);
    localparam logic signed [POS_W-1:0] PMIN_P = POS_W'(PMIN_Q);
    localparam logic signed [POS_W-1:0] PMAX_P = POS_W'(PMAX_Q);
    localparam logic signed [VEL_W-1:0] VMAX_V = VEL_W'(VMAX_Q);
    localparam logic signed [AW-1:0] PI_A     = AW'(PI_Q);
    localparam logic signed [AW-1:0] TWO_PI_A = AW'(2 * PI_Q);
    localparam logic signed [AW-1:0] HALF_A   = AW'(HALF_PI_Q);

    logic                      noise_en_reg;
    logic                      linear_reg;
    logic [CFG_DATA_W-1:0]     delay_reg;

    logic [ACT_W-1:0]          in_action_reg;
    logic signed [NOISE_W-1:0] in_noise_reg;
    logic signed [POS_W-1:0]   in_lpos_reg;
    logic signed [VEL_W-1:0]   in_lvel_reg;

    logic signed [POS_W-1:0]   pos_reg;
    logic signed [VEL_W-1:0]   vel_reg;
    logic signed [POS_W-1:0]   fill_pos_reg;
    logic signed [VEL_W-1:0]   fill_vel_reg;
    logic [MAX_DELAY-1:0]      valid_reg;
    logic [PTR_W-1:0]          ptr_reg;
    logic [PTR_W-1:0]          k_reg;

    logic signed [MW-1:0]      ang_reg;
    logic                      neg_reg;
    logic signed [MW-1:0]      actv_reg;
    logic signed [MW-1:0]      t2_reg;
    logic signed [MW-1:0]      grav_reg;
    logic signed [PW-1:0]      prod_reg;
    logic [OUT_W-1:0]          out_reg;

    logic [EFF_W-1:0]          eff;
    logic                      delay_on;
    logic [PTR_W-1:0]          k_next;
    logic [EFF_W-1:0]          k_inc;
    logic [PTR_W-1:0]          ptr_next;

    logic signed [AW-1:0]      a3, a1, a2, a_abs, a_red;
    logic                      a_neg;
    logic signed [MW-1:0]      act_base, actv_next;

    logic signed [PW-1:0]      rnd_wide, q56_wide, q30_wide, q12_wide;
    logic signed [MW-1:0]      rnd;
    logic signed [MW-1:0]      cos_pos, cos_val;
    logic signed [MW-1:0]      mul_a, mul_b;
    logic signed [PW-1:0]      prod_next;

    logic signed [MW-1:0]      nv_sum, nv_clamp;
    logic signed [POS_W:0]     np_sum;
    logic signed [POS_W-1:0]   np_fin, lpos_c, hist_pos, new_pos;
    logic signed [VEL_W-1:0]   nv_fin, lvel_c, hist_vel, new_vel;
    logic                      at_goal;

    logic [POS_W+VEL_W-1:0]    ram_rdata;
    logic                      ram_we;

    assign status.linear_mode = linear_reg;

    assign eff = (EFF_W'(delay_reg) > EFF_W'(MAX_DELAY)) ? EFF_W'(MAX_DELAY)
                                                        : EFF_W'(delay_reg);
    assign delay_on = (eff != '0);
    assign k_next   = (EFF_W'(ptr_reg) >= eff) ? '0 : ptr_reg;
    assign k_inc    = EFF_W'(k_reg) + EFF_W'(1);
    assign ptr_next = (k_inc >= eff) ? '0 : k_inc[PTR_W-1:0];

    always_comb begin
        a3 = AW'(pos_reg) + (AW'(pos_reg) <<< 1);
        a1 = (a3 > PI_A) ? a3 - TWO_PI_A : a3;
        a2 = (a1 < -PI_A) ? a1 + TWO_PI_A : a1;
        a_abs = (a2 < 0) ? -a2 : a2;
        a_neg = (a_abs > HALF_A);
        a_red = a_neg ? PI_A - a_abs : a_abs;
    end

    always_comb begin
        case (in_action_reg)
            ACT_LEFT: act_base = -ONE_M;
            ACT_NONE: act_base = '0;
            default:  act_base = ONE_M;
        endcase
        actv_next = act_base + (noise_en_reg ? MW'(in_noise_reg) : MW'(0));
    end

    assign rnd_wide = (prod_reg + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign rnd      = rnd_wide[MW-1:0];
    assign q56_wide = prod_reg >>> S56;
    assign q30_wide = prod_reg >>> S30;
    assign q12_wide = prod_reg >>> S12;
    assign cos_pos  = ONE_M - (rnd >>> 1);
    assign cos_val  = neg_reg ? -cos_pos : cos_pos;

    always_comb begin
        case (cmd.op)
            OP_SQ: begin
                mul_a = ang_reg;
                mul_b = ang_reg;
            end
            OP_D56: begin
                mul_a = rnd;
                mul_b = MW'(M56);
            end
            OP_M1: begin
                mul_a = t2_reg;
                mul_b = ONE_M - q56_wide[MW-1:0];
            end
            OP_D30: begin
                mul_a = rnd;
                mul_b = MW'(M30);
            end
            OP_M2: begin
                mul_a = t2_reg;
                mul_b = ONE_M - q30_wide[MW-1:0];
            end
            OP_D12: begin
                mul_a = rnd;
                mul_b = MW'(M12);
            end
            OP_M3: begin
                mul_a = t2_reg;
                mul_b = ONE_M - q12_wide[MW-1:0];
            end
            OP_KC: begin
                mul_a = MW'(K_COS);
                mul_b = cos_val;
            end
            OP_KL: begin
                mul_a = MW'(K_LIN);
                mul_b = MW'(pos_reg);
            end
            OP_GR: begin
                mul_a = MW'(K_ACT);
                mul_b = actv_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PW'(mul_a) * PW'(mul_b);

    always_comb begin
        nv_sum = MW'(vel_reg) + rnd + grav_reg;
        if (nv_sum > VMAX_M) begin
            nv_clamp = VMAX_M;
        end else if (nv_sum < -VMAX_M) begin
            nv_clamp = -VMAX_M;
        end else begin
            nv_clamp = nv_sum;
        end
        np_sum = (POS_W + 1)'(pos_reg) + (POS_W + 1)'(vel_reg);
        if (np_sum < PMIN_E && nv_clamp < 0) begin
            nv_fin = '0;
        end else begin
            nv_fin = nv_clamp[VEL_W-1:0];
        end
        if (np_sum < PMIN_E) begin
            np_fin = PMIN_P;
        end else if (np_sum > PMAX_E) begin
            np_fin = PMAX_P;
        end else begin
            np_fin = np_sum[POS_W-1:0];
        end
    end

    always_comb begin
        if (in_lpos_reg < PMIN_P) begin
            lpos_c = PMIN_P;
        end else if (in_lpos_reg > PMAX_P) begin
            lpos_c = PMAX_P;
        end else begin
            lpos_c = in_lpos_reg;
        end
        if (in_lvel_reg < -VMAX_V) begin
            lvel_c = -VMAX_V;
        end else if (in_lvel_reg > VMAX_V) begin
            lvel_c = VMAX_V;
        end else begin
            lvel_c = in_lvel_reg;
        end
    end

    assign hist_pos = valid_reg[k_reg] ? ram_rdata[POS_W-1:0] : fill_pos_reg;
    assign hist_vel = valid_reg[k_reg] ? ram_rdata[POS_W+VEL_W-1:POS_W] : fill_vel_reg;

    always_comb begin
        if (cmd.commit_load) begin
            new_pos = lpos_c;
            new_vel = lvel_c;
        end else if (delay_on) begin
            new_pos = hist_pos;
            new_vel = hist_vel;
        end else begin
            new_pos = np_fin;
            new_vel = nv_fin;
        end
    end

    assign at_goal = (new_pos >= PMAX_P);
    assign ram_we  = cmd.commit_step && delay_on;

    mcd_ram #(
        .WIDTH (POS_W + VEL_W),
        .DEPTH (MAX_DELAY)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (k_reg),
        .wdata ({nv_fin, np_fin}),
        .re    (cmd.reduce),
        .raddr (k_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_en_reg <= 1'b0;
            linear_reg   <= 1'b0;
            delay_reg    <= '0;
            pos_reg      <= '0;
            vel_reg      <= '0;
            fill_pos_reg <= '0;
            fill_vel_reg <= '0;
            valid_reg    <= '0;
            ptr_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_NOISE_EN: noise_en_reg <= cfg_wdata[0];
                    REG_LINEAR:   linear_reg   <= cfg_wdata[0];
                    REG_DELAY:    delay_reg    <= cfg_wdata;
                    default:      ;
                endcase
            end
            if (cmd.commit_load) begin
                pos_reg      <= new_pos;
                vel_reg      <= new_vel;
                fill_pos_reg <= new_pos;
                fill_vel_reg <= new_vel;
                valid_reg    <= '0;
                ptr_reg      <= '0;
            end
            if (cmd.commit_step) begin
                pos_reg <= new_pos;
                vel_reg <= new_vel;
                if (delay_on) begin
                    valid_reg[k_reg] <= 1'b1;
                    ptr_reg          <= ptr_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_action_reg <= s_tdata[ACT_W-1:0];
            in_noise_reg  <= s_tdata[LPOS_LO-1:NOISE_LO];
            in_lpos_reg   <= s_tdata[LVEL_LO-1:LPOS_LO];
            in_lvel_reg   <= s_tdata[LVEL_LO+VEL_W-1:LVEL_LO];
        end
        if (cmd.reduce) begin
            ang_reg  <= MW'(a_red);
            neg_reg  <= a_neg;
            actv_reg <= actv_next;
            k_reg    <= k_next;
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
            if (cmd.op == OP_D56) begin
                t2_reg <= rnd;
            end
            if (cmd.op == OP_GR) begin
                grav_reg <= -rnd;
            end
        end
        if (cmd.commit_step || cmd.commit_load) begin
            out_reg <= {at_goal, ~at_goal, new_vel, new_pos};
        end
    end

    assign m_tdata = M_TDATA_W'(out_reg);

endmodule
`default_nettype wire

// ===== src/mcd_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mountain car controller
// Sequences request capture, angle reduction, multiplier steps and commit.
// ----------------------------------------------------------------------------
module mcd_controller (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tuser,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output mcd_pkg::mcd_cmd_t         cmd,
    input  wire mcd_pkg::mcd_status_t status
);
    import mcd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_RED,
        S_SQ,
        S_D56,
        S_M1,
        S_D30,
        S_M2,
        S_D12,
        S_M3,
        S_KC,
        S_KL,
        S_GR,
        S_UPD
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;
    logic   accept;
    logic   commit;

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign commit    = cmd.commit_step || cmd.commit_load;

    always_comb begin
        cmd             = '0;
        cmd.op          = OP_SQ;
        state_next      = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                cmd.capture = accept;
                if (accept) begin
                    state_next = s_tuser ? S_LOAD : S_RED;
                end
            end
            S_LOAD: begin
                cmd.commit_load = slot_free;
                if (slot_free) begin
                    state_next = S_IDLE;
                end
            end
            S_RED: begin
                cmd.reduce = 1'b1;
                state_next = status.linear_mode ? S_KL : S_SQ;
            end
            S_SQ: begin
                cmd.mul_en = 1'b1;
                cmd.op     = OP_SQ;
                state_next = S_D56;
            end
            S_D56: begin
                cmd.mul_en = 1'b1;
                cmd.op     = OP_D56;
                state_next = S_M1;
            end
            S_M1: begin
                cmd.mul_en = 1'b1;
                cmd.op     = OP_M1;
                state_next = S_D30;
            end
            S_D30: begin
                cmd.mul_en = 1'b1;
                cmd.op     = OP_D30;
                state_next = S_M2;
            end
            S_M2: begin
                cmd.mul_en = 1'b1;
                cmd.op     = OP_M2;
                state_next = S_D12;
            end
            S_D12: begin
                cmd.mul_en = 1'b1;
                cmd.op     = OP_D12;
                state_next = S_M3;
            end
            S_M3: begin
                cmd.mul_en = 1'b1;
                cmd.op     = OP_M3;
                state_next = S_KC;
            end
            S_KC: begin
                cmd.mul_en = 1'b1;
                cmd.op     = OP_KC;
                state_next = S_GR;
            end
            S_KL: begin
                cmd.mul_en = 1'b1;
                cmd.op     = OP_KL;
                state_next = S_GR;
            end
            S_GR: begin
                cmd.mul_en = 1'b1;
                cmd.op     = OP_GR;
                state_next = S_UPD;
            end
            S_UPD: begin
                cmd.commit_step = slot_free;
                if (slot_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (commit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_commit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |-> (!out_valid_reg || m_tready))
        else $error("Result committed while the output register was still full.");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("Controller stayed ready after accepting a request.");

    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.reduce, cmd.mul_en, cmd.commit_step, cmd.commit_load}))
        else $error("More than one datapath command issued in a cycle.");

    a_commit_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_tvalid)
        else $error("Committed result was not presented.");
`endif

endmodule
`default_nettype wire

// ===== src/mountain_car_dynamics_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mountain car dynamics step
// Fixed-point mountain car environment step with optional observation delay.
//
//   Channel   Direction  Contents
//   s_*       in         tuser: command; tdata: action, noise, load position,
//                        load velocity
//   m_*       out        tdata: position, velocity, reward value, goal flag
//   cfg_*     in         noise enable, linear mode, delay steps
//
// A cosine step runs nine dependent products on the single shared multiplier
// between acceptance and a registered result; a linear step runs only the
// linear and action products, and a load commits directly. A new request is
// accepted in the cycle after the result is registered. A stalled result holds
// the block before its commit cycle. Reset is synchronous and clears the car
// state, configuration and delay line at once.
// ----------------------------------------------------------------------------
module mountain_car_dynamics_step (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [mcd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [mcd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // action[1:0], noise[22:2], load_position[44:23], load_velocity[62:45]
    input  wire logic [mcd_pkg::S_TDATA_W-1:0]   s_tdata,
    // command[0]
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // position[21:0], velocity[39:22], reward_value[40], at_goal[41]
    output logic      [mcd_pkg::M_TDATA_W-1:0]   m_tdata
);
    import mcd_pkg::*;

    mcd_cmd_t    cmd;
    mcd_status_t status;

    mcd_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    mcd_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire
